// ===== src/scw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scw_pkg
// Shared types and constants for the send credit window.
// ----------------------------------------------------------------------------
package scw_pkg;

	localparam int unsigned SLOT_COUNT_WIDTH_DEF = 16;

	localparam logic [7:0] CREDIT_FLAG_MASK = 8'h01;

	localparam logic [31:0] SERIAL_HALF = 32'h8000_0000;

	typedef logic [2:0] cmd_t;
	localparam cmd_t CMD_INIT     = 3'd0;
	localparam cmd_t CMD_ACQUIRE  = 3'd1;
	localparam cmd_t CMD_ABORT    = 3'd2;
	localparam cmd_t CMD_COMPLETE = 3'd3;
	localparam cmd_t CMD_REFRESH  = 3'd4;
	localparam cmd_t CMD_QUERY    = 3'd5;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK             = 3'd0;
	localparam status_t ST_BAD_FLAGS      = 3'd1;
	localparam status_t ST_QUEUE_FULL     = 3'd2;
	localparam status_t ST_NO_CREDITS     = 3'd3;
	localparam status_t ST_NOTHING_POSTED = 3'd4;
	localparam status_t ST_NO_CREDIT_USED = 3'd5;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_QUEUE_DEPTH = 1'd0;
	localparam cfg_idx_t CFG_INIT_LIMIT  = 1'd1;

endpackage

// ===== src/send_credit_window_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// send_credit_window_core
// Admission control for a send path against a local slot budget and a
// remote receive credit budget.
// ----------------------------------------------------------------------------
// Takes one command per cycle unless the output stalls, and returns exactly
// one result per command. A command is captured in an input register; its
// decision, the counter update and the result are then computed in one pass
// and the result lands in the output register, so throughput is one command
// per clock while the output does not stall. The posted count, credits used
// and credit limit close a loop from that pass through their registers back
// to itself, which is what allows each command to see the effect of the one
// before it. Write configuration only while no command is in flight.
module send_credit_window_core #(
	parameter int unsigned SLOT_COUNT_WIDTH = scw_pkg::SLOT_COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  scw_pkg::cmd_t        cmd,
	input  logic [7:0]           flags,
	input  logic [31:0]          new_credit_limit,
	output logic                 out_valid,
	input  logic                 out_stall,
	output scw_pkg::status_t     status,
	output logic [15:0]          free_send_slots,
	output logic [31:0]          free_remote_credits,
	output logic [15:0]          available_for_flags,
	input  logic                 cfg_we,
	input  scw_pkg::cfg_idx_t    cfg_index,
	input  logic [31:0]          cfg_data
);
	import scw_pkg::*;

	localparam int unsigned SW = SLOT_COUNT_WIDTH;

	logic [15:0]   queue_depth_q;
	logic [31:0]   init_limit_q;
	logic [SW-1:0] posted_q;
	logic [31:0]   used_q;
	logic [31:0]   limit_q;

	logic          v_s1;
	cmd_t          cmd_s1;
	logic [7:0]    flags_s1;
	logic [31:0]   newlim_s1;

	logic          adv;
	logic          fire;

	logic [SW-1:0] depth;
	logic          flags_ok;
	logic          want_cr;
	logic          slots_zero;
	logic          creds_zero;
	status_t       st_d;
	logic [SW-1:0] posted_d;
	logic [31:0]   used_d;
	logic [31:0]   limit_d;
	logic [SW-1:0] slots_d;
	logic [31:0]   creds_d;
	logic [31:0]   slots_ext;
	logic [31:0]   avail_d;

	assign adv      = !out_valid || !out_stall;
	assign fire     = v_s1 && adv;
	assign in_stall = v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_depth_q <= 16'd1;
			init_limit_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_QUEUE_DEPTH: queue_depth_q <= cfg_data[15:0];
				CFG_INIT_LIMIT:  init_limit_q  <= cfg_data;
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1    <= cmd;
			flags_s1  <= flags;
			newlim_s1 <= new_credit_limit;
		end
	end

	assign depth      = SW'(queue_depth_q);
	assign flags_ok   = (flags_s1 & ~CREDIT_FLAG_MASK) == 8'd0;
	assign want_cr    = (flags_s1 & CREDIT_FLAG_MASK) != 8'd0;
	assign slots_zero = posted_q >= depth;
	assign creds_zero = limit_q == used_q;

	always_comb begin
		st_d     = ST_OK;
		posted_d = posted_q;
		used_d   = used_q;
		limit_d  = limit_q;
		case (cmd_s1)
			CMD_INIT: begin
				posted_d = '0;
				used_d   = '0;
				limit_d  = init_limit_q;
			end
			CMD_ACQUIRE: begin
				if (!flags_ok) begin
					st_d = ST_BAD_FLAGS;
				end else if (slots_zero) begin
					st_d = ST_QUEUE_FULL;
				end else if (want_cr && creds_zero) begin
					st_d = ST_NO_CREDITS;
				end else begin
					posted_d = posted_q + SW'(1);
					if (want_cr) begin
						used_d = used_q + 32'd1;
					end
				end
			end
			CMD_ABORT: begin
				if (!flags_ok) begin
					st_d = ST_BAD_FLAGS;
				end else if (posted_q == '0) begin
					st_d = ST_NOTHING_POSTED;
				end else if (want_cr && used_q == 32'd0) begin
					st_d = ST_NO_CREDIT_USED;
				end else begin
					posted_d = posted_q - SW'(1);
					if (want_cr) begin
						used_d = used_q - 32'd1;
					end
				end
			end
			CMD_COMPLETE: begin
				if (posted_q == '0) begin
					st_d = ST_NOTHING_POSTED;
				end else begin
					posted_d = posted_q - SW'(1);
				end
			end
			CMD_REFRESH: begin
				if ((newlim_s1 - limit_q) < SERIAL_HALF) begin
					limit_d = newlim_s1;
				end
			end
			default: ;
		endcase
	end

	assign slots_d   = (posted_d >= depth) ? '0 : depth - posted_d;
	assign creds_d   = limit_d - used_d;
	assign slots_ext = 32'(slots_d);

	always_comb begin
		if (!flags_ok) begin
			avail_d = '0;
		end else if (want_cr && creds_d < slots_ext) begin
			avail_d = creds_d;
		end else begin
			avail_d = slots_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			posted_q <= '0;
			used_q   <= '0;
			limit_q  <= '0;
		end else if (fire) begin
			posted_q <= posted_d;
			used_q   <= used_d;
			limit_q  <= limit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status              <= st_d;
			free_send_slots     <= slots_ext[15:0];
			free_remote_credits <= creds_d;
			available_for_flags <= avail_d[15:0];
		end
	end

	a_posted_step: assert property (@(posedge clk) disable iff (!arst_n)
		posted_q != $past(posted_q) |->
			(posted_q == $past(posted_q) + SW'(1)) ||
			(posted_q == $past(posted_q) - SW'(1)) ||
			(posted_q == '0))
		else $error("posted count moved by more than one");

	a_acquire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd_s1 == CMD_ACQUIRE && st_d == ST_OK |=>
			posted_q == $past(posted_q) + SW'(1))
		else $error("granted acquire did not take a slot");

	a_limit_src: assert property (@(posedge clk) disable iff (!arst_n)
		limit_q != $past(limit_q) |->
			$past(fire) && ($past(cmd_s1) == CMD_INIT || $past(cmd_s1) == CMD_REFRESH))
		else $error("credit limit changed without init or refresh");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(fire))
		else $error("result appeared without a command");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

endmodule

// ===== bench/send_credit_window_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// send_credit_window_core_test
// Self-checking bench for the send credit window. It issues a short directed
// run of commands, then random phases under several queue depth and credit
// limit settings. The bench tracks the slot and credit counters itself to
// predict each result, and it checks every field of every result. The input
// side idles and the output stalls at random outside the steady phase.
// ----------------------------------------------------------------------------
module send_credit_window_core_test;
	import scw_pkg::*;

	localparam cmd_t CMD_SPARE_6 = 3'd6;
	localparam cmd_t CMD_SPARE_7 = 3'd7;
	localparam int   IDLE_PCT    = 23;
	localparam int   SETTLE      = 4;
	localparam int   STUCK_LIMIT = 2000;

	typedef struct packed {
		status_t     status;
		logic [15:0] slots;
		logic [31:0] credits;
		logic [15:0] avail;
	} window_reply_t;

	class window_scoreboard;
		bit [15:0]     depth = 16'd1;
		bit [31:0]     seed_limit = 32'd0;
		bit [15:0]     posted = 16'd0;
		bit [31:0]     used = 32'd0;
		bit [31:0]     limit = 32'd0;
		window_reply_t awaited_replies[$];
		int            failures = 0;
		int            replies_checked = 0;
		int            commands_noted = 0;
		int            status_hits[8];

		function void apply_register(cfg_idx_t idx, logic [31:0] val);
			if (idx == CFG_QUEUE_DEPTH)
				depth = val[15:0];
			else
				seed_limit = val;
		endfunction

		function bit [15:0] open_slots();
			return (posted >= depth) ? 16'd0 : depth - posted;
		endfunction

		function void note_command(cmd_t op, logic [7:0] fl, logic [31:0] offer);
			bit            bad;
			bit            want;
			bit [31:0]     spare;
			bit [31:0]     slots;
			bit [31:0]     creds;
			status_t       st;
			window_reply_t r;
			bad = (fl & ~CREDIT_FLAG_MASK) != 8'h00;
			want = (fl & CREDIT_FLAG_MASK) != 8'h00;
			st = ST_OK;
			spare = limit - used;
			case (op)
				CMD_INIT: begin
					posted = 16'd0;
					used = 32'd0;
					limit = seed_limit;
				end
				CMD_ACQUIRE: begin
					if (bad)
						st = ST_BAD_FLAGS;
					else if (open_slots() == 16'd0)
						st = ST_QUEUE_FULL;
					else if (want && spare == 32'd0)
						st = ST_NO_CREDITS;
					else begin
						posted = posted + 16'd1;
						if (want)
							used = used + 32'd1;
					end
				end
				CMD_ABORT: begin
					if (bad)
						st = ST_BAD_FLAGS;
					else if (posted == 16'd0)
						st = ST_NOTHING_POSTED;
					else if (want && used == 32'd0)
						st = ST_NO_CREDIT_USED;
					else begin
						posted = posted - 16'd1;
						if (want)
							used = used - 32'd1;
					end
				end
				CMD_COMPLETE: begin
					if (posted == 16'd0)
						st = ST_NOTHING_POSTED;
					else
						posted = posted - 16'd1;
				end
				CMD_REFRESH: begin
					spare = offer - limit;
					if (spare < SERIAL_HALF)
						limit = offer;
				end
				default: begin
				end
			endcase
			slots = {16'd0, open_slots()};
			creds = limit - used;
			r.status = st;
			r.slots = slots[15:0];
			r.credits = creds;
			if (bad)
				r.avail = 16'd0;
			else if (want)
				r.avail = (slots < creds) ? slots[15:0] : creds[15:0];
			else
				r.avail = slots[15:0];
			awaited_replies.push_back(r);
			status_hits[st]++;
			commands_noted++;
		endfunction

		function void check_reply(window_reply_t got);
			window_reply_t want;
			if (awaited_replies.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected result status %0d slots %0d credits %0h avail %0d",
						$realtime, got.status, got.slots, got.credits, got.avail);
				return;
			end
			want = awaited_replies.pop_front();
			replies_checked++;
			if (got !== want) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: result %0d mismatch", $realtime, replies_checked);
					$display("  status  expected %0d actual %0d", want.status, got.status);
					$display("  slots   expected %0d actual %0d", want.slots, got.slots);
					$display("  credits expected %0h actual %0h", want.credits, got.credits);
					$display("  avail   expected %0d actual %0d", want.avail, got.avail);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	cmd_t        cmd;
	logic [7:0]  flags;
	logic [31:0] new_credit_limit;
	logic        out_valid;
	logic        out_stall;
	status_t     status;
	logic [15:0] free_send_slots;
	logic [31:0] free_remote_credits;
	logic [15:0] available_for_flags;
	logic        cfg_we;
	cfg_idx_t    cfg_index;
	logic [31:0] cfg_data;

	window_scoreboard sb = new();
	bit steady = 1'b0;
	int stuck_cycles = 0;
	int settings_run = 0;

	send_credit_window_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.flags(flags),
		.new_credit_limit(new_credit_limit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.free_send_slots(free_send_slots),
		.free_remote_credits(free_remote_credits),
		.available_for_flags(available_for_flags),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0)
			sb.check_reply({status, free_send_slots, free_remote_credits, available_for_flags});
	end

	// end the run if no transfer happens on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
			stuck_cycles <= 0;
		else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", STUCK_LIMIT);
			$display("send_credit_window_core_test NOT OK");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

	task automatic send_command(cmd_t op, logic [7:0] fl, logic [31:0] offer);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		flags <= fl;
		new_credit_limit <= offer;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_command(op, fl, offer);
	endtask

	task automatic wait_for_replies();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.awaited_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.apply_register(idx, val);
	endtask

	function automatic logic [7:0] pick_flags();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return 8'h00;
		if (r < 80)
			return CREDIT_FLAG_MASK;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [31:0] pick_limit();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return sb.limit + $urandom_range(6) - 2;
		if (r < 65)
			return sb.limit + SERIAL_HALF + $urandom_range(4) - 2;
		if (r < 80)
			return sb.limit - $urandom_range(8);
		return $urandom;
	endfunction

	function automatic cmd_t pick_cmd();
		int r;
		r = $urandom_range(99);
		if (r < 35) return CMD_ACQUIRE;
		if (r < 50) return CMD_ABORT;
		if (r < 68) return CMD_COMPLETE;
		if (r < 80) return CMD_REFRESH;
		if (r < 88) return CMD_QUERY;
		if (r < 92) return CMD_INIT;
		if (r < 96) return CMD_SPARE_6;
		return CMD_SPARE_7;
	endfunction

	task automatic run_directed();
		send_command(CMD_QUERY, 8'h00, 32'd0);
		send_command(CMD_ACQUIRE, CREDIT_FLAG_MASK, 32'd0);
		send_command(CMD_ACQUIRE, 8'h00, 32'd0);
		send_command(CMD_ACQUIRE, 8'h00, 32'd0);
		send_command(CMD_ACQUIRE, 8'h80, 32'd0);
		send_command(CMD_ABORT, 8'hFE, 32'd0);
		send_command(CMD_ABORT, CREDIT_FLAG_MASK, 32'd0);
		send_command(CMD_COMPLETE, 8'h00, 32'hFFFF_FFFF);
		send_command(CMD_COMPLETE, 8'h00, 32'd0);
		send_command(CMD_ABORT, 8'h00, 32'd0);
		send_command(CMD_REFRESH, 8'h00, 32'd10);
		send_command(CMD_REFRESH, 8'h00, 32'd5);
		send_command(CMD_REFRESH, 8'hFF, 32'h8000_000A);
		send_command(CMD_REFRESH, 8'h00, 32'h8000_0009);
		send_command(CMD_ACQUIRE, CREDIT_FLAG_MASK, 32'd0);
		send_command(CMD_QUERY, CREDIT_FLAG_MASK, 32'd0);
		send_command(CMD_ABORT, CREDIT_FLAG_MASK, 32'd0);
		send_command(CMD_ACQUIRE, 8'h00, 32'd0);
		send_command(CMD_COMPLETE, 8'hFF, 32'd0);
		send_command(CMD_SPARE_6, 8'hFF, 32'hFFFF_FFFF);
		send_command(CMD_SPARE_7, 8'h00, 32'd0);
		send_command(CMD_INIT, 8'hFF, 32'd0);
	endtask

	initial begin
		logic [31:0] depth_val;
		logic [31:0] limit_val;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_QUERY;
		flags = 8'h00;
		new_credit_limit = 32'd0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_QUEUE_DEPTH;
		cfg_data = 32'd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		settings_run = 1;

		for (int phase = 0; phase < 6; phase++) begin
			wait_for_replies();
			case (phase)
				0: begin depth_val = 32'd4;     limit_val = 32'd3; end
				1: begin depth_val = 32'd0;     limit_val = 32'd0; end
				2: begin depth_val = 32'd65535; limit_val = 32'hFFFF_FFFF; end
				3: begin depth_val = 32'd3;     limit_val = 32'h7FFF_FFFE; end
				4: begin
					depth_val = $urandom_range(16, 1);
					limit_val = $urandom_range(12);
				end
				default: begin depth_val = 32'd2; limit_val = $urandom; end
			endcase
			write_register(CFG_QUEUE_DEPTH, depth_val);
			write_register(CFG_INIT_LIMIT, limit_val);
			settings_run++;
			steady = (phase == 2);
			send_command(CMD_INIT, pick_flags(), $urandom);
			for (int n = 0; n < 70; n++) begin
				if ($urandom_range(99) < 2)
					wait_for_replies();
				send_command(pick_cmd(), pick_flags(), pick_limit());
			end
		end

		steady = 1'b0;
		wait_for_replies();

		if (sb.awaited_replies.size() != 0)
			sb.failures++;
		$display("Ran %0d commands under %0d register settings, %0d results checked.",
			sb.commands_noted, settings_run, sb.replies_checked);
		$display("Statuses: ok %0d, bad flags %0d, queue full %0d, no credits %0d, %s %0d, %s %0d",
			sb.status_hits[ST_OK], sb.status_hits[ST_BAD_FLAGS],
			sb.status_hits[ST_QUEUE_FULL], sb.status_hits[ST_NO_CREDITS],
			"nothing posted", sb.status_hits[ST_NOTHING_POSTED],
			"no credit used", sb.status_hits[ST_NO_CREDIT_USED]);
		if (sb.failures == 0)
			$display("send_credit_window_core_test OK");
		else
			$display("send_credit_window_core_test NOT OK");
		$finish;
	end

endmodule
